### design/mma_pkg.sv
package mma_pkg;

  // Filter geometry
  localparam int WINDOW      = 8;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;

  // Derived widths
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int SCNT_W = $clog2(SUM_W + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Scaling path widths
  localparam int TCH_W  = 2;
  localparam int VREF_W = 13;
  localparam int FS_W   = 16;
  localparam int TEMP_W = 16;
  localparam int PROD_W = SAMPLE_BITS + VREF_W;
  localparam int DCNT_W = $clog2(TEMP_W + 1);

  // Stream widths, padded to whole bytes
  localparam int IN_W        = CHANNELS * SAMPLE_BITS;
  localparam int OUT_W       = CHANNELS * SAMPLE_BITS + TEMP_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd2;

  localparam logic [VREF_W-1:0] VREF_RST = 13'd3300;
  localparam logic [FS_W-1:0]   FS_RST   = 16'd4095;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Per-word control broadcast to every lane
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] divisor;
  } lane_ctrl_t;

endpackage

### design/multichannel_moving_average.sv
// Flow per input word: a 15-step serial divider in each channel lane, then the scaling
// unit (select, multiply, overflow check, 16-step divider), then hand-over and the output
// load. A saturated reading skips the divider.
// One frame at a time: no new frame is taken until its word loads, later while the output stalls.
// Reset (rst, synchronous): sample rings, sums, write index and full flag clear,
// registers return to temp_channel 0, vref_mv 3300, full_scale 4095.
module multichannel_moving_average (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  logic [mma_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // average_ch0, average_ch1, average_ch2, average_ch3, temp_tenths
  output logic [mma_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // window_full
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SB  = mma_pkg::SAMPLE_BITS;
  localparam int NCH = mma_pkg::CHANNELS;
  localparam int IW  = mma_pkg::IDX_W;
  localparam int CW  = mma_pkg::CNT_W;
  localparam int OTW = mma_pkg::OUT_TDATA_W;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_LANE  = 2'd1;
  localparam logic [1:0] T_SCALE = 2'd2;
  localparam logic [1:0] T_OUT   = 2'd3;

  logic [1:0]                      state;
  logic [mma_pkg::TCH_W-1:0]       temp_channel;
  logic [mma_pkg::VREF_W-1:0]      vref_mv;
  logic [mma_pkg::FS_W-1:0]        full_scale;
  logic [IW-1:0]                   wr_idx;
  logic                            filled;

  logic                            accept;
  logic                            load;
  logic [CW-1:0]                   idx_inc;
  logic                            wrap;
  logic [IW-1:0]                   idx_next;
  logic                            filled_next;
  logic [CW-1:0]                   divisor_next;
  mma_pkg::lane_ctrl_t             lane_ctrl;
  logic [NCH-1:0][SB-1:0]          averages;
  logic [NCH-1:0]                  lane_done;
  logic                            scale_start;
  logic                            scale_done;
  logic [mma_pkg::TEMP_W-1:0]      scale_result;

  assign s_tready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign load      = (state == T_OUT) && (!m_tvalid || m_tready);

  // Write index advance and divisor for the frame just taken
  assign idx_inc      = CW'(wr_idx) + 1'b1;
  assign wrap         = (idx_inc == CW'(mma_pkg::WINDOW));
  assign idx_next     = wrap ? '0 : idx_inc[IW-1:0];
  assign filled_next  = filled || wrap;
  assign divisor_next = filled_next ? CW'(mma_pkg::WINDOW) :
                        (idx_next == '0) ? CW'(1) : CW'(idx_next);

  assign lane_ctrl.start   = accept;
  assign lane_ctrl.wr_idx  = wr_idx;
  assign lane_ctrl.divisor = divisor_next;

  // One lane per channel
  for (genvar c = 0; c < NCH; c++) begin : g_lane
    mma_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .sample  (s_tdata[c*SB +: SB]),
      .average (averages[c]),
      .done    (lane_done[c])
    );
  end

  assign scale_start = (state == T_LANE) && (&lane_done);

  // Merge stage: scaled reading of the selected channel
  mma_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .start        (scale_start),
    .averages     (averages),
    .temp_channel (temp_channel),
    .vref_mv      (vref_mv),
    .full_scale   (full_scale),
    .result       (scale_result),
    .done         (scale_done)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_channel <= '0;
      vref_mv      <= mma_pkg::VREF_RST;
      full_scale   <= mma_pkg::FS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mma_pkg::CFG_TEMP_CHANNEL: temp_channel <= cfg_data[mma_pkg::TCH_W-1:0];
        mma_pkg::CFG_VREF_MV:      vref_mv      <= cfg_data[mma_pkg::VREF_W-1:0];
        mma_pkg::CFG_FULL_SCALE:   full_scale   <= cfg_data[mma_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, write index and full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      wr_idx <= '0;
      filled <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            wr_idx <= idx_next;
            filled <= filled_next;
            state  <= T_LANE;
          end
        end
        T_LANE: begin
          if (&lane_done) begin
            state <= T_SCALE;
          end
        end
        T_SCALE: begin
          if (scale_done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (load) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OTW'({scale_result, averages});
      m_tuser <= filled;
    end
  end

endmodule

### design/mma_lane.sv
module mma_lane (
  input  logic                clk,
  input  logic                rst,
  input  mma_pkg::lane_ctrl_t ctrl,
  input  mma_pkg::sample_t    sample,
  output mma_pkg::sample_t    average,
  output logic                done
);

  localparam int SW  = mma_pkg::SUM_W;
  localparam int SB  = mma_pkg::SAMPLE_BITS;
  localparam int CW  = mma_pkg::CNT_W;
  localparam int NW  = mma_pkg::SCNT_W;
  localparam int WIN = mma_pkg::WINDOW;

  mma_pkg::sample_t ring [WIN];
  logic [SW-1:0]    sum;
  logic [SW-1:0]    quot;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    divisor;
  logic [NW-1:0]    steps;
  logic             busy;

  logic [SW-1:0]    sum_next;
  logic [CW:0]      trial;
  logic             ge;
  logic [CW:0]      diff;
  logic [CW-1:0]    rem_next;

  // Running sum: drop the oldest sample, add the new one
  assign sum_next = sum - SW'(ring[ctrl.wr_idx]) + SW'(sample);

  // One restoring division step per cycle
  assign trial    = {rem, quot[SW-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];

  assign average = quot[SB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN; i++) begin
        ring[i] <= '0;
      end
      sum   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        ring[ctrl.wr_idx] <= sample;
        sum               <= sum_next;
        quot              <= sum_next;
        rem               <= '0;
        divisor           <= ctrl.divisor;
        steps             <= '0;
        busy              <= 1'b1;
      end else if (busy) begin
        quot  <= {quot[SW-2:0], ge};
        rem   <= rem_next;
        steps <= steps + 1'b1;
        if (steps == NW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/mma_scale.sv
module mma_scale (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 start,
  input  logic [mma_pkg::CHANNELS-1:0][mma_pkg::SAMPLE_BITS-1:0] averages,
  input  logic [mma_pkg::TCH_W-1:0]                            temp_channel,
  input  logic [mma_pkg::VREF_W-1:0]                           vref_mv,
  input  logic [mma_pkg::FS_W-1:0]                             full_scale,
  output logic [mma_pkg::TEMP_W-1:0]                           result,
  output logic                                                 done
);

  localparam int SB  = mma_pkg::SAMPLE_BITS;
  localparam int PW  = mma_pkg::PROD_W;
  localparam int TW  = mma_pkg::TEMP_W;
  localparam int FW  = mma_pkg::FS_W;
  localparam int DW  = mma_pkg::DCNT_W;
  localparam int CHW = mma_pkg::CH_W;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_CHK  = 2'd2;
  localparam logic [1:0] SC_DIV  = 2'd3;

  logic [1:0]                  state;
  logic [SB-1:0]               avg_sel;
  logic [mma_pkg::VREF_W-1:0]  vref_r;
  logic [FW-1:0]               fs;
  logic [PW-1:0]               prod;
  logic [FW-1:0]               rem;
  logic [TW-1:0]               quot;
  logic [DW-1:0]               steps;

  logic [SB-1:0]               sel;
  logic [FW-1:0]               prod_hi;
  logic [FW:0]                 trial;
  logic                        ge;
  logic [FW:0]                 diff;

  // Channel select; a channel beyond the lane count reads as zero
  assign sel = (int'(temp_channel) < mma_pkg::CHANNELS) ? averages[temp_channel[CHW-1:0]] : '0;

  // Quotient overflows 16 bits exactly when the upper product bits reach the divisor
  assign prod_hi = FW'(prod[PW-1:TW]);

  assign trial = {rem, quot[TW-1]};
  assign ge    = trial >= {1'b0, fs};
  assign diff  = trial - {1'b0, fs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        SC_IDLE: begin
          if (start) begin
            avg_sel <= sel;
            vref_r  <= vref_mv;
            fs      <= full_scale;
            state   <= SC_MUL;
          end
        end
        SC_MUL: begin
          prod  <= PW'(avg_sel) * PW'(vref_r);
          state <= SC_CHK;
        end
        SC_CHK: begin
          // also covers a zero full scale
          if (prod_hi >= fs) begin
            result <= '1;
            done   <= 1'b1;
            state  <= SC_IDLE;
          end else begin
            rem   <= prod_hi;
            quot  <= prod[TW-1:0];
            steps <= '0;
            state <= SC_DIV;
          end
        end
        SC_DIV: begin
          rem   <= ge ? diff[FW-1:0] : trial[FW-1:0];
          quot  <= {quot[TW-2:0], ge};
          steps <= steps + 1'b1;
          if (steps == DW'(TW - 1)) begin
            result <= {quot[TW-2:0], ge};
            done   <= 1'b1;
            state  <= SC_IDLE;
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

endmodule

### design/mma_checker.sv
module mma_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mma_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tuser
);

  // No word offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // One frame in flight: input closes once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after accepting a word");

  // A new result only appears while the input side is closed
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result produced while input was open");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);

### test/multichannel_moving_average_test.sv
`timescale 1ns / 1ps

module multichannel_moving_average_test;

  localparam int CHANNELS    = mma_pkg::CHANNELS;
  localparam int WINDOW      = mma_pkg::WINDOW;
  localparam int SAMPLE_BITS = mma_pkg::SAMPLE_BITS;
  localparam int SUM_W       = mma_pkg::SUM_W;
  localparam int IDX_W       = mma_pkg::IDX_W;
  localparam int TCH_W       = mma_pkg::TCH_W;
  localparam int VREF_W      = mma_pkg::VREF_W;
  localparam int FS_W        = mma_pkg::FS_W;
  localparam int TEMP_W      = mma_pkg::TEMP_W;
  localparam int IN_W        = mma_pkg::IN_W;
  localparam int IN_TDATA_W  = mma_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = mma_pkg::OUT_TDATA_W;
  localparam int CFG_IDX_W   = mma_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = mma_pkg::CFG_DATA_W;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 48;   // extra wait after the last expected word
  localparam int HOLD_CYCLES    = 300;  // long output stall for the pressure test
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_FRAMES   = 100;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] avg;
    logic [TEMP_W-1:0]                    temp_tenths;
    logic                                 window_full;
  } filter_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_W-1:0]     s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]    m_tdata;
  logic                      m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // Filter state as predicted
  mma_pkg::sample_t          ring [CHANNELS][WINDOW];
  sum_t                      sums [CHANNELS];
  logic [IDX_W-1:0]          wr_pos;
  logic                      filled;
  logic [TCH_W-1:0]          sel_channel;
  logic [VREF_W-1:0]         vref;
  logic [FS_W-1:0]           fscale;

  filter_result_t            pending_results [$];
  int unsigned               errors = 0;
  int unsigned               burst_left = 0;
  int unsigned               idle_cycles = 0;
  bit                        hold_request = 0;

  multichannel_moving_average uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Predicted state after reset
  task automatic clear_filter();
    for (int c = 0; c < CHANNELS; c++) begin
      sums[c] = '0;
      for (int s = 0; s < WINDOW; s++) ring[c][s] = '0;
    end
    wr_pos      = '0;
    filled      = 1'b0;
    sel_channel = '0;
    vref        = mma_pkg::VREF_RST;
    fscale      = mma_pkg::FS_RST;
  endtask

  // Push one frame through the predicted rings and work out the output word
  function automatic filter_result_t advance_filter(input frame_t frame);
    filter_result_t r;
    int unsigned    div;
    logic [63:0]    prod;
    logic [63:0]    quot;
    for (int c = 0; c < CHANNELS; c++) begin
      sums[c] = sums[c] - sum_t'(ring[c][wr_pos]) + sum_t'(frame[c]);
      ring[c][wr_pos] = frame[c];
    end
    if (wr_pos == IDX_W'(WINDOW - 1)) begin
      wr_pos = '0;
      filled = 1'b1;
    end else begin
      wr_pos = wr_pos + 1'b1;
    end
    // divisor is the frame count until the ring has wrapped
    if (filled) div = WINDOW;
    else if (wr_pos == '0) div = 1;
    else div = 32'(wr_pos);
    for (int c = 0; c < CHANNELS; c++) r.avg[c] = SAMPLE_BITS'(sums[c] / div);
    if (int'(sel_channel) < CHANNELS) prod = 64'(r.avg[sel_channel]) * 64'(vref);
    else prod = '0;
    if (fscale == '0) quot = 64'd65535;
    else quot = prod / 64'(fscale);
    if (quot > 64'd65535) quot = 64'd65535;
    r.temp_tenths = TEMP_W'(quot);
    r.window_full = filled;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps
  task automatic send_frame(input frame_t frame);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(frame);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(advance_filter(frame));
  endtask

  // Stop sending and let every expected word come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mma_pkg::CFG_TEMP_CHANNEL: sel_channel = data[TCH_W-1:0];
      mma_pkg::CFG_VREF_MV:      vref        = data[VREF_W-1:0];
      mma_pkg::CFG_FULL_SCALE:   fscale      = data[FS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(0, 9))
        0:       f[c] = '0;
        1:       f[c] = '1;
        default: f[c] = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      endcase
    end
    return f;
  endfunction

  // Fill the window from reset, wrap it and slide past the wrap
  task automatic test_window_fill();
    frame_t f;
    send_frame('0);
    send_frame('1);
    send_frame({CHANNELS{12'hAAA}});
    send_frame({CHANNELS{12'h555}});
    send_frame({12'd0, 12'hFFF, 12'd2, 12'd1});
    send_frame({12'hFFF, 12'd0, 12'd1, 12'd2});
    send_frame('1);
    send_frame('1);
    // first frame slid out of the window
    send_frame('0);
    f = {12'h123, 12'h800, 12'h7FF, 12'h001};
    send_frame(f);
  endtask

  // Saturation, zero divisor, zero reference and a dropped register write
  task automatic test_scaling_limits();
    drain();
    write_register(mma_pkg::CFG_FULL_SCALE, 16'd1);
    write_register(mma_pkg::CFG_VREF_MV, 16'hFFFF);
    write_register(mma_pkg::CFG_TEMP_CHANNEL, 16'hFFFF);
    send_frame('1);
    send_frame({12'hFFF, 12'h000, 12'hFFF, 12'h000});
    drain();
    write_register(mma_pkg::CFG_FULL_SCALE, 16'd0);
    send_frame('0);
    send_frame({CHANNELS{12'h001}});
    drain();
    write_register(mma_pkg::CFG_VREF_MV, 16'd0);
    write_register(mma_pkg::CFG_FULL_SCALE, 16'hFFFF);
    send_frame('1);
    drain();
    write_register(CFG_UNUSED, 16'hFFFF);
    send_frame({12'h800, 12'h400, 12'h200, 12'h100});
    drain();
    write_register(mma_pkg::CFG_VREF_MV, 16'd5000);
    write_register(mma_pkg::CFG_FULL_SCALE, 16'd4095);
    write_register(mma_pkg::CFG_TEMP_CHANNEL, 16'd1);
    send_frame('1);
    send_frame({12'h000, 12'h000, 12'h000, 12'hFFF});
  endtask

  // Random frames under a fresh register setting each phase
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] data;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      write_register(mma_pkg::CFG_TEMP_CHANNEL, CFG_DATA_W'($urandom_range(0, 65535)));
      case ($urandom_range(0, 3))
        0:       data = CFG_DATA_W'($urandom_range(0, 65535));
        default: data = CFG_DATA_W'($urandom_range(0, 5000));
      endcase
      write_register(mma_pkg::CFG_VREF_MV, data);
      case ($urandom_range(0, 5))
        0:       data = '0;
        1:       data = CFG_DATA_W'($urandom_range(1, 64));
        2:       data = CFG_DATA_W'($urandom_range(1, 65535));
        default: data = CFG_DATA_W'($urandom_range(1000, 8191));
      endcase
      write_register(mma_pkg::CFG_FULL_SCALE, data);
      if ($urandom_range(0, 1) == 0) write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
      for (int i = 0; i < PHASE_FRAMES; i++) send_frame(random_frame());
    end
  endtask

  // Long output stall while frames keep coming, so the input backs up
  task automatic test_output_backpressure();
    drain();
    write_register(mma_pkg::CFG_TEMP_CHANNEL, 16'd2);
    write_register(mma_pkg::CFG_VREF_MV, 16'd3300);
    write_register(mma_pkg::CFG_FULL_SCALE, 16'd4095);
    hold_request = 1;
    burst_left = 60;
    for (int i = 0; i < 40; i++) send_frame(random_frame());
  endtask

  // Receiver: randomly changing stall styles, plus the long hold
  initial begin : receiver
    int unsigned span;
    int unsigned style;
    int unsigned hold_left;
    span = 0;
    style = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 2);
          span  = $urandom_range(20, 120);
        end
        span--;
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare every output word with the oldest prediction
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: output word with nothing expected: tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        for (int c = 0; c < CHANNELS; c++) begin
          if (m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] !== want.avg[c]) begin
            $display("%0t: average_ch%0d expected %0d actual %0d", $time, c,
                     want.avg[c], m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
            errors++;
          end
        end
        if (m_tdata[IN_W +: TEMP_W] !== want.temp_tenths) begin
          $display("%0t: temp_tenths expected %0d actual %0d", $time,
                   want.temp_tenths, m_tdata[IN_W +: TEMP_W]);
          errors++;
        end
        if (m_tuser !== want.window_full) begin
          $display("%0t: window_full expected %b actual %b", $time,
                   want.window_full, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on any port
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("multichannel_moving_average verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_filter();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_window_fill();
    test_scaling_limits();
    test_random_traffic();
    test_output_backpressure();
    drain();
    if (errors == 0) begin
      $display("multichannel_moving_average verification clean");
    end else begin
      $display("multichannel_moving_average verification failed");
    end
    $finish;
  end

endmodule
